### rtl/bcd_binary_converter_assert.svh
// Assertion macros for the BCD/binary converter.
// Used by the pipeline stage and output buffer modules; no other dependencies.
`ifndef BCD_BINARY_CONVERTER_ASSERT_SVH
`define BCD_BINARY_CONVERTER_ASSERT_SVH
`ifndef SYNTH
// a holds in the same cycle as c
`define BCDC_ASSERT_NOW(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("bcdc check failed");
// a holds, then c holds in the next cycle
`define BCDC_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("bcdc check failed");
`else
`define BCDC_ASSERT_NOW(label, clk, rst, a, c)
`define BCDC_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

### rtl/bcdc_pkg.sv
// Shared types, constants and helpers for the BCD/binary converter.
// No dependencies; imported by every module of the block.
package bcdc_pkg;

  localparam int WORD_NIBBLES = 8;
  localparam int DIGITS_DEF   = 8;
  localparam int VAL_W        = 27;
  localparam int BIN_W        = 28;
  localparam int BCD_W        = 32;

  // divide by ten as multiply by reciprocal, exact for any 32-bit dividend
  localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;
  localparam logic [3:0]  NIB_MAX     = 4'd9;

  localparam logic REQ_BCD2BIN = 1'b0;
  localparam logic REQ_BIN2BCD = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [BCD_W-1:0]  bcd_word;
    logic [VAL_W-1:0]  bin_value;
  } req_t;

  typedef struct packed {
    logic [BIN_W-1:0]  bin_result;
    logic [BCD_W-1:0]  bcd_result;
    logic              bad_digit;
  } rsp_t;

  // working item as it moves down the digit stages
  typedef struct packed {
    logic              req_type;
    logic [BCD_W-1:0]  word;
    logic [VAL_W-1:0]  val;
    logic [BIN_W-1:0]  bin;
    logic [BCD_W-1:0]  bcd;
    logic              bad;
  } pipe_t;

  // weight of decimal digit k, modulo 2^BIN_W
  function automatic logic [BIN_W-1:0] pow10(input int k);
    logic [BIN_W-1:0] w;
    w = BIN_W'(1);
    for (int i = 0; i < k; i++) begin
      w = BIN_W'(w * BIN_W'(10));
    end
    return w;
  endfunction

endpackage

### rtl/bcd_binary_converter.sv
// Top level of the BCD/binary converter: digit stage chain plus output buffer.
// Depends on bcdc_pkg, bcdc_stage and bcdc_out_buf.
//
//   Channel | Handshake              | Payload
//   --------+------------------------+---------------------------------------
//   request | req_valid / req_ready  | req: req_type, bcd_word, bin_value
//   result  | rsp_valid / rsp_ready  | rsp: bin_result, bcd_result, bad_digit
//
// One request enters per cycle while req_ready is high; each gives one result
// after one register stage per decimal digit, then the output register. Each
// digit stage holds one reciprocal multiply for the divide by ten. Reset (rst,
// synchronous) empties every stage. A stalled result holds in the output
// register and a skid entry; stages behind it fill up and then drop req_ready,
// losing nothing.
module bcd_binary_converter
  import bcdc_pkg::*;
#(
  parameter int DIGITS = DIGITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  // digit positions past the 32-bit word are dropped
  localparam int STAGES = (DIGITS < WORD_NIBBLES) ? DIGITS : WORD_NIBBLES;

  logic  chain_valid [STAGES+1];
  logic  chain_ready [STAGES+1];
  pipe_t chain_data  [STAGES+1];
  pipe_t head;

  // load the request with empty accumulators
  always_comb begin
    head.req_type = req.req_type;
    head.word     = req.bcd_word;
    head.val      = req.bin_value;
    head.bin      = '0;
    head.bcd      = '0;
    head.bad      = 1'b0;
  end

  assign chain_data[0]  = head;
  assign chain_valid[0] = req_valid;
  assign req_ready      = chain_ready[0];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    bcdc_stage #(
      .K (k)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[k]),
      .up_ready (chain_ready[k]),
      .up_data  (chain_data[k]),
      .dn_valid (chain_valid[k+1]),
      .dn_ready (chain_ready[k+1]),
      .dn_data  (chain_data[k+1])
    );
  end

  bcdc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (chain_valid[STAGES]),
    .up_ready  (chain_ready[STAGES]),
    .up_data   (chain_data[STAGES]),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

### rtl/bcdc_stage.sv
// One digit stage of the converter pipeline: handles decimal digit K in both directions.
// Depends on bcdc_pkg and bcd_binary_converter_assert.svh.
`include "bcd_binary_converter_assert.svh"
module bcdc_stage
  import bcdc_pkg::*;
#(
  parameter int K = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  output logic  up_ready,
  input  pipe_t up_data,
  output logic  dn_valid,
  input  logic  dn_ready,
  output pipe_t dn_data
);

  localparam logic [BIN_W-1:0] WEIGHT = pow10(K);

  logic                        valid;
  pipe_t                       data;
  pipe_t                       data_next;
  logic [3:0]                  nib;
  logic [31:0]                 nib_term;
  logic [VAL_W+32-1:0]         prod;
  logic [VAL_W-1:0]            quot;
  logic [VAL_W-1:0]            rem_full;

  // weigh one BCD nibble, or peel one decimal digit off the binary value
  always_comb begin
    nib      = up_data.word[4*K +: 4];
    nib_term = 32'(nib) * 32'(WEIGHT);
    prod     = (VAL_W+32)'(up_data.val) * (VAL_W+32)'(RECIP_10);
    quot     = VAL_W'(prod >> RECIP_SHIFT);
    rem_full = up_data.val - (quot << 3) - (quot << 1);
    data_next = up_data;
    if (up_data.req_type == REQ_BCD2BIN) begin
      data_next.bin = up_data.bin + nib_term[BIN_W-1:0];
      if (nib > NIB_MAX) begin
        data_next.bad = 1'b1;
      end
    end else begin
      data_next.val          = quot;
      data_next.bcd[4*K +: 4] = rem_full[3:0];
    end
  end

  // advance when the stage is empty or its content moves on
  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

  `BCDC_ASSERT_NOW(a_b2d_no_flag, clk, rst, valid && data.req_type == REQ_BIN2BCD, !data.bad && data.bin == '0)
  `BCDC_ASSERT_NOW(a_d2b_no_bcd, clk, rst, valid && data.req_type == REQ_BCD2BIN, data.bcd == '0)
  `BCDC_ASSERT_NEXT(a_stall_keeps, clk, rst, valid && !dn_ready, valid && $stable(data))

endmodule

### rtl/bcdc_out_buf.sv
// Output register with a skid entry; packs the finished item into a response.
// Depends on bcdc_pkg and bcd_binary_converter_assert.svh.
`include "bcd_binary_converter_assert.svh"
module bcdc_out_buf
  import bcdc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  output logic  up_ready,
  input  pipe_t up_data,
  output logic  rsp_valid,
  input  logic  rsp_ready,
  output rsp_t  rsp
);

  logic main_v;
  logic skid_v;
  rsp_t main;
  rsp_t skid;
  rsp_t packed_rsp;
  logic up_xfer;

  always_comb begin
    packed_rsp.bin_result = up_data.bin;
    packed_rsp.bcd_result = up_data.bcd;
    packed_rsp.bad_digit  = up_data.bad;
  end

  // ready comes from a register, so it has no combinational path from rsp_ready
  assign up_ready = !skid_v;
  assign up_xfer  = up_valid && up_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (!main_v || rsp_ready) begin
      // main frees up: refill from skid first, else from the pipeline
      if (skid_v) begin
        main_v <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        main_v <= up_xfer;
      end
    end else if (up_xfer) begin
      // main held: park the arriving transfer
      skid_v <= 1'b1;
    end
    if (!main_v || rsp_ready) begin
      if (skid_v) begin
        main <= skid;
      end else if (up_xfer) begin
        main <= packed_rsp;
      end
    end else if (up_xfer) begin
      skid <= packed_rsp;
    end
  end

  assign rsp_valid = main_v;
  assign rsp       = main;

  `BCDC_ASSERT_NOW(a_skid_behind_main, clk, rst, skid_v, main_v)
  `BCDC_ASSERT_NEXT(a_skid_kept, clk, rst, skid_v && !rsp_ready, skid_v && main_v)
  `BCDC_ASSERT_NOW(a_flag_only_d2b, clk, rst, main_v && main.bad_digit, main.bcd_result == '0)

endmodule

### tb/tb_bcd_binary_converter.sv
// Self-checking testbench for bcd_binary_converter: directed and random conversions in both
// directions, random idling on the request and result channels.
// Depends on bcdc_pkg and the converter RTL only.
module tb_bcd_binary_converter
  import bcdc_pkg::*;
();

  localparam int CONV_DIGITS  = DIGITS_DEF;
  localparam int RANDOM_ITEMS = 1930;
  localparam int DRAIN_CYCLES = 30;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  bit   sender_quiet;
  bit   receiver_quiet;

  // Scoreboard: predicts each conversion and checks results in order
  class conv_scoreboard;
    rsp_t pending_conversions[$];
    int   errors;
    int   to_bin_count;
    int   to_bcd_count;
    int   flagged_count;
    int   wrapped_count;

    function new();
      errors        = 0;
      to_bin_count  = 0;
      to_bcd_count  = 0;
      flagged_count = 0;
      wrapped_count = 0;
    endfunction

    // Weight nibbles by powers of ten, or split the value into decimal digits
    function rsp_t convert_request(req_t r);
      rsp_t            res;
      logic [3:0]      nib;
      longint unsigned acc;
      longint unsigned weight;
      longint unsigned val;
      res = '0;
      if (r.req_type == REQ_BCD2BIN) begin
        acc    = 0;
        weight = 1;
        for (int k = 0; k < CONV_DIGITS && k < 16; k++) begin
          nib = (k < WORD_NIBBLES) ? r.bcd_word[4*k +: 4] : 4'd0;
          if (nib > NIB_MAX) res.bad_digit = 1'b1;
          acc    = acc + nib * weight;
          weight = weight * 10;
        end
        res.bin_result = acc[BIN_W-1:0];
      end else begin
        val = r.bin_value;
        for (int k = 0; k < CONV_DIGITS && k < 16; k++) begin
          if (k < WORD_NIBBLES) res.bcd_result[4*k +: 4] = 4'(val % 10);
          val = val / 10;
        end
      end
      return res;
    endfunction

    function void note_request(req_t r);
      rsp_t want;
      want = convert_request(r);
      if (r.req_type == REQ_BCD2BIN) begin
        to_bin_count++;
        if (want.bad_digit) flagged_count++;
      end else begin
        to_bcd_count++;
        if (r.bin_value > 27'd99999999) wrapped_count++;
      end
      pending_conversions.push_back(want);
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (pending_conversions.size() == 0) begin
        $error("result with no request outstanding: bin_result=%0d bcd_result=%h bad_digit=%0b",
               got.bin_result, got.bcd_result, got.bad_digit);
        errors++;
        return;
      end
      want = pending_conversions.pop_front();
      if (got.bin_result !== want.bin_result) begin
        $error("bin_result: expected %0d, got %0d", want.bin_result, got.bin_result);
        errors++;
      end
      if (got.bcd_result !== want.bcd_result) begin
        $error("bcd_result: expected %h, got %h", want.bcd_result, got.bcd_result);
        errors++;
      end
      if (got.bad_digit !== want.bad_digit) begin
        $error("bad_digit: expected %0b, got %0b", want.bad_digit, got.bad_digit);
        errors++;
      end
    endfunction
  endclass

  conv_scoreboard scoreboard = new();

  bcd_binary_converter DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones; none at all in quiet stretches
  function automatic int idle_cycles(bit quiet);
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Hold the request until the transfer, then return at the next falling edge
  task automatic send_request(input req_t r);
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    scoreboard.note_request(r);
    @(negedge clk);
  endtask

  task automatic send_with_gap(input req_t r);
    int gap;
    gap = idle_cycles(sender_quiet);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    send_request(r);
  endtask

  // Mostly well-formed BCD words and in-range values, with raw noise mixed in
  function automatic req_t random_request();
    req_t r;
    int   roll;
    r.bcd_word  = $urandom;
    r.bin_value = VAL_W'($urandom);
    if ($urandom_range(0, 99) < 45) begin
      r.req_type = REQ_BCD2BIN;
      if ($urandom_range(0, 9) < 7) begin
        for (int k = 0; k < WORD_NIBBLES; k++) r.bcd_word[4*k +: 4] = 4'($urandom_range(0, 9));
      end
    end else begin
      r.req_type = REQ_BIN2BCD;
      roll = $urandom_range(0, 9);
      if (roll < 8) r.bin_value = VAL_W'($urandom_range(0, 99999999));
      else if (roll < 9) r.bin_value = VAL_W'($urandom_range(0, 999));
    end
    return r;
  endfunction

  // Result side: random back-pressure, with stretches of steady acceptance
  initial begin
    int hold;
    hold           = 0;
    receiver_quiet = 1'b0;
    rsp_ready      = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 299) == 0) receiver_quiet = ~receiver_quiet;
      if (hold > 0) begin
        hold--;
      end else if (receiver_quiet || $urandom_range(0, 3) != 0) begin
        rsp_ready <= 1'b1;
        hold = $urandom_range(0, 6);
      end else begin
        rsp_ready <= 1'b0;
        hold = idle_cycles(1'b0);
      end
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) scoreboard.check_result(rsp);
  end

  // Main sequence: reset, directed cases, random traffic, drain
  initial begin
    req_t r;
    int   drain;
    rst          = 1'b1;
    req_valid    = 1'b0;
    req          = '0;
    sender_quiet = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // BCD to binary: zero, all nines, all F, ordinary words
    r = '0;
    r.req_type = REQ_BCD2BIN;
    r.bin_value = VAL_W'($urandom);
    r.bcd_word = 32'h0000_0000; send_with_gap(r);
    r.bcd_word = 32'h9999_9999; send_with_gap(r);
    r.bcd_word = 32'hFFFF_FFFF; send_with_gap(r);
    r.bcd_word = 32'h1234_5678; send_with_gap(r);
    r.bcd_word = 32'h8765_4321; send_with_gap(r);
    // one non-decimal nibble in each position
    for (int k = 0; k < WORD_NIBBLES; k++) begin
      r.bcd_word = 32'h9999_9999;
      r.bcd_word[4*k +: 4] = 4'(10 + k % 6);
      send_with_gap(r);
    end

    // Binary to BCD: extremes, decade edges and values past eight digits
    r.req_type = REQ_BIN2BCD;
    r.bcd_word = $urandom;
    r.bin_value = 27'd0;         send_with_gap(r);
    r.bin_value = 27'd1;         send_with_gap(r);
    r.bin_value = 27'd9;         send_with_gap(r);
    r.bin_value = 27'd10;        send_with_gap(r);
    r.bin_value = 27'd12345678;  send_with_gap(r);
    r.bin_value = 27'd99999999;  send_with_gap(r);
    r.bin_value = 27'd100000000; send_with_gap(r);
    r.bin_value = 27'h7FF_FFFF;  send_with_gap(r);

    // Random traffic, switching between idle and back-to-back stretches
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
      send_with_gap(random_request());
    end
    req_valid <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (scoreboard.pending_conversions.size() != 0) @(posedge clk);
    for (drain = 0; drain < DRAIN_CYCLES; drain++) @(posedge clk);

    $display("Covered %0d BCD-to-binary requests (%0d with non-decimal nibbles)",
             scoreboard.to_bin_count, scoreboard.flagged_count);
    $display("and %0d binary-to-BCD requests (%0d above eight digits).",
             scoreboard.to_bcd_count, scoreboard.wrapped_count);
    if (scoreboard.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
